FILE: rtl/fdtms_pkg.sv
`timescale 1ns / 1ps

package fdtms_pkg;

    // Stream widths
    localparam int REQ_W        = 2;
    localparam int CAUSE_W      = 2;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 64;

    // Request kinds carried on the input tuser
    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STRUCT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    // Finish causes carried on the output tuser
    localparam logic [CAUSE_W-1:0] CAUSE_REG     = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_END     = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_UNKNOWN = 2'd2;

    // Structure block tokens
    localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
    localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
    localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
    localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
    localparam logic [31:0] TOK_END        = 32'h0000_0009;

    // Name characters
    localparam logic [7:0] CH_M = 8'h6d;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_Y = 8'h79;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_G = 8'h67;

endpackage

FILE: rtl/fdt_memory_size_scanner.sv
`timescale 1ns / 1ps
// A result leaves on m_axis from the output register, after its item has passed stage 1.
// Throughput: one item per cycle unless m_axis stalls; set by a store read pair, a 64-bit add.
// A strings load writes the store at its input transfer; later items see the byte.
// Reset clears all parse state and both stream stages; the strings store is not cleared
// and holds undefined bytes until loaded. A restart request clears parse state only.
module fdt_memory_size_scanner #(
    parameter int STRINGS_DEPTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] strings_addr, [19:12] strings_byte, [51:20] struct_word, [55:52] zero
    input  logic [fdtms_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] req_type
    input  logic [fdtms_pkg::REQ_W-1:0]          s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [63:0] total_size
    output logic [fdtms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [1:0] finish_cause
    output logic [fdtms_pkg::CAUSE_W-1:0]        m_axis_tuser
);
    import fdtms_pkg::*;

    localparam int AW = $clog2(STRINGS_DEPTH);

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_NAME,
        PH_NAME_TAIL,
        PH_PROP_LEN,
        PH_PROP_OFF,
        PH_SKIP,
        PH_SUM
    } phase_t;

    function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    function automatic logic has_zero_byte(input logic [31:0] w);
        return (w[31:24] == 8'd0) || (w[23:16] == 8'd0) ||
               (w[15:8] == 8'd0) || (w[7:0] == 8'd0);
    endfunction

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic [11:0] in_addr;
    logic [7:0]  in_byte;
    logic [31:0] in_word;
    logic        s_fire;
    logic        load_in_range;

    assign in_addr = s_axis_tdata[11:0];
    assign in_byte = s_axis_tdata[19:12];
    assign in_word = s_axis_tdata[51:20];
    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign load_in_range = 32'(in_addr) < 32'(STRINGS_DEPTH);

    // ------------------------------------------------------------------
    // Strings store: one write port, two registered read ports.
    // Reads are issued at every input transfer with the incoming word as
    // the name offset, so the read data lines up with the item in stage 1.
    // A load writes here at its own transfer, ahead of any later read.
    // ------------------------------------------------------------------
    logic [7:0]  strings_mem [STRINGS_DEPTH];
    logic [7:0]  rd0_reg;
    logic [7:0]  rd1_reg;
    logic [31:0] in_word_plus2;

    assign in_word_plus2 = in_word + 32'd2;

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            if ((s_axis_tuser == REQ_LOAD) && load_in_range)
            begin
                strings_mem[AW'(in_addr)] <= in_byte;
            end
            rd0_reg <= strings_mem[AW'(in_word)];
            rd1_reg <= strings_mem[AW'(in_word_plus2)];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: item held with its store read data, executed against the
    // parse state when the output register can take a result.
    // ------------------------------------------------------------------
    logic             s1_valid_reg;
    logic [REQ_W-1:0] s1_req_reg;
    logic [31:0]      s1_word_reg;

    logic out_free;
    logic exe_fire;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign exe_fire      = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_req_reg  <= s_axis_tuser;
            s1_word_reg <= in_word;
        end
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    phase_t      phase_reg,       phase_next;
    logic        in_mem_reg,      in_mem_next;
    logic        name_idx_reg,    name_idx_next;
    logic [31:0] prop_len_reg,    prop_len_next;
    logic [30:0] skip_left_reg,   skip_left_next;
    logic [27:0] entries_reg,     entries_next;
    logic [1:0]  entry_idx_reg,   entry_idx_next;
    logic [31:0] size_hi_reg,     size_hi_next;
    logic [63:0] total_reg,       total_next;
    logic        finished_reg,    finished_next;

    logic               emit;
    logic [63:0]        emit_total;
    logic [CAUSE_W-1:0] emit_cause;

    logic        name_ok;
    logic        word_ends;
    logic [63:0] sum_val;
    logic [27:0] entries_dec;

    assign word_ends = has_zero_byte(s1_word_reg);
    // Name offset must leave room for byte 2 inside the store.
    assign name_ok = (s1_word_reg <= 32'(STRINGS_DEPTH - 3)) &&
                     (rd0_reg == CH_R) && (rd1_reg == CH_G);
    assign sum_val = total_reg + {size_hi_reg, s1_word_reg};
    assign entries_dec = (entries_reg != 28'd0) ? entries_reg - 28'd1 : entries_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        in_mem_next    = in_mem_reg;
        name_idx_next  = name_idx_reg;
        prop_len_next  = prop_len_reg;
        skip_left_next = skip_left_reg;
        entries_next   = entries_reg;
        entry_idx_next = entry_idx_reg;
        size_hi_next   = size_hi_reg;
        total_next     = total_reg;
        finished_next  = finished_reg;
        emit           = 1'b0;
        emit_total     = 64'd0;
        emit_cause     = CAUSE_REG;

        if (exe_fire)
        begin
            if (s1_req_reg == REQ_RESTART)
            begin
                phase_next     = PH_TOKEN;
                in_mem_next    = 1'b0;
                name_idx_next  = 1'b0;
                prop_len_next  = 32'd0;
                skip_left_next = 31'd0;
                entries_next   = 28'd0;
                entry_idx_next = 2'd0;
                size_hi_next   = 32'd0;
                total_next     = 64'd0;
                finished_next  = 1'b0;
            end
            else if ((s1_req_reg == REQ_STRUCT) && !finished_reg)
            begin
                unique case (phase_reg)
                    PH_TOKEN:
                    begin
                        total_next = 64'd0;
                        priority if (s1_word_reg == TOK_BEGIN_NODE)
                        begin
                            in_mem_next   = 1'b0;
                            name_idx_next = 1'b0;
                            phase_next    = PH_NAME;
                        end
                        else if (s1_word_reg == TOK_PROP)
                        begin
                            phase_next = PH_PROP_LEN;
                        end
                        else if (s1_word_reg == TOK_END_NODE)
                        begin
                            in_mem_next = 1'b0;
                        end
                        else if (s1_word_reg == TOK_NOP)
                        begin
                            phase_next = PH_TOKEN;
                        end
                        else if (s1_word_reg == TOK_END)
                        begin
                            emit       = 1'b1;
                            emit_cause = CAUSE_END;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            emit_cause = CAUSE_UNKNOWN;
                        end
                    end
                    PH_NAME:
                    begin
                        if (!name_idx_reg)
                        begin
                            // A name ending inside its first word never matches.
                            in_mem_next   = !word_ends &&
                                            (byte_of(s1_word_reg, 2'd0) == CH_M) &&
                                            (byte_of(s1_word_reg, 2'd1) == CH_E);
                            name_idx_next = 1'b1;
                            phase_next    = word_ends ? PH_TOKEN : PH_NAME;
                        end
                        else
                        begin
                            if (!((byte_of(s1_word_reg, 2'd0) != 8'd0) &&
                                  (byte_of(s1_word_reg, 2'd1) == CH_Y)))
                            begin
                                in_mem_next = 1'b0;
                            end
                            phase_next = word_ends ? PH_TOKEN : PH_NAME_TAIL;
                        end
                    end
                    PH_NAME_TAIL:
                    begin
                        if (word_ends)
                        begin
                            phase_next = PH_TOKEN;
                        end
                    end
                    PH_PROP_LEN:
                    begin
                        prop_len_next = s1_word_reg;
                        phase_next    = PH_PROP_OFF;
                    end
                    PH_PROP_OFF:
                    begin
                        if (in_mem_reg && name_ok)
                        begin
                            entries_next = prop_len_reg[31:4];
                            if (prop_len_reg[31:4] == 28'd0)
                            begin
                                // Short value: report an empty sum at once.
                                emit = 1'b1;
                            end
                            else
                            begin
                                entry_idx_next = 2'd0;
                                total_next     = 64'd0;
                                phase_next     = PH_SUM;
                            end
                        end
                        else
                        begin
                            // Skip the value, padded to whole words.
                            skip_left_next = 31'(prop_len_reg[31:2]) +
                                             31'(|prop_len_reg[1:0]);
                            phase_next = ((prop_len_reg[31:2] != 30'd0) ||
                                          (|prop_len_reg[1:0])) ? PH_SKIP : PH_TOKEN;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (skip_left_reg <= 31'd1)
                        begin
                            phase_next = PH_TOKEN;
                        end
                        if (skip_left_reg != 31'd0)
                        begin
                            skip_left_next = skip_left_reg - 31'd1;
                        end
                    end
                    PH_SUM:
                    begin
                        entry_idx_next = entry_idx_reg + 2'd1;
                        if (entry_idx_reg == 2'd2)
                        begin
                            size_hi_next = s1_word_reg;
                        end
                        else if (entry_idx_reg == 2'd3)
                        begin
                            total_next   = sum_val;
                            entries_next = entries_dec;
                            if (entries_dec == 28'd0)
                            begin
                                entry_idx_next = 2'd0;
                                emit           = 1'b1;
                                emit_total     = sum_val;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_TOKEN;
                    end
                endcase

                if (emit)
                begin
                    finished_next = 1'b1;
                    phase_next    = PH_TOKEN;
                end
            end
        end
    end

    // Control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            m_axis_tvalid <= 1'b0;
            phase_reg     <= PH_TOKEN;
            in_mem_reg    <= 1'b0;
            name_idx_reg  <= 1'b0;
            prop_len_reg  <= 32'd0;
            skip_left_reg <= 31'd0;
            entries_reg   <= 28'd0;
            entry_idx_reg <= 2'd0;
            size_hi_reg   <= 32'd0;
            total_reg     <= 64'd0;
            finished_reg  <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (exe_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (exe_fire && emit)
            begin
                m_axis_tvalid <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end

            phase_reg     <= phase_next;
            in_mem_reg    <= in_mem_next;
            name_idx_reg  <= name_idx_next;
            prop_len_reg  <= prop_len_next;
            skip_left_reg <= skip_left_next;
            entries_reg   <= entries_next;
            entry_idx_reg <= entry_idx_next;
            size_hi_reg   <= size_hi_next;
            total_reg     <= total_next;
            finished_reg  <= finished_next;
        end
    end

    // Output payload: load only with a new result
    always_ff @(posedge clk)
    begin
        if (exe_fire && emit)
        begin
            m_axis_tdata <= emit_total;
            m_axis_tuser <= emit_cause;
        end
    end

endmodule

FILE: rtl/fdtms_checker.sv
`timescale 1ns / 1ps
module fdtms_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [fdtms_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic [fdtms_pkg::REQ_W-1:0]        s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [fdtms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [fdtms_pkg::CAUSE_W-1:0]      m_axis_tuser
);
    import fdtms_pkg::*;

    // Result cause is one of the three defined codes.
    a_cause_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == CAUSE_REG) || (m_axis_tuser == CAUSE_END) ||
                          (m_axis_tuser == CAUSE_UNKNOWN))
        else $error("finish cause out of range");

    // END and unknown-token results carry a zero total.
    a_token_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == CAUSE_END) || (m_axis_tuser == CAUSE_UNKNOWN))
        |-> (m_axis_tdata == '0))
        else $error("nonzero total on token finish");

    // Input stalls only behind a result that is itself stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // Held result stays valid.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Held result keeps its payload.
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind fdt_memory_size_scanner fdtms_checker u_fdtms_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import fdtms_pkg::*;

    localparam int STR_DEPTH    = 4096;
    localparam int STR_LAST_OFF = STR_DEPTH - 3;   // highest offset whose pair fits the store
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEM_GOAL    = 400;

    // Request code that the block never acts on
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        SC_TOKEN,
        SC_NAME,
        SC_NAME_TAIL,
        SC_PROP_LEN,
        SC_PROP_OFF,
        SC_SKIP,
        SC_SUM
    } scan_phase_t;

    typedef struct packed {
        logic [63:0]        total;
        logic [CAUSE_W-1:0] cause;
    } region_total_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [11:0]        addr;
        logic [7:0]         data_byte;
        logic [31:0]        word;
        logic               has_total;
        logic [63:0]        total;
        logic [CAUSE_W-1:0] cause;
    } opening_row_t;

    // Opening walk: load a "r?g" name at offset 0 and 0xff at the top byte, then
    // cover an ignored code, a name that ends in its first word, a zero-length
    // property, an offset beyond the store, a wrapping sum,
    // words ignored after a result, an unknown token and END.
    localparam int OPENING_ROWS = 34;
    localparam opening_row_t OPENING [OPENING_ROWS] = '{
        '{REQ_LOAD,    12'd0,   CH_R,  32'h0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_LOAD,    12'd2,   CH_G,  32'h0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_LOAD,    12'hfff, 8'hff, 32'h0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_UNUSED,  12'hfff, 8'hff, 32'hffff_ffff,    1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, TOK_BEGIN_NODE,   1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'h6d65_0000,    1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, TOK_PROP,         1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, TOK_BEGIN_NODE,   1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'h6d65_6d6f,    1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'h7279_0000,    1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, TOK_PROP,         1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd4,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'hffff_ffff,    1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, TOK_PROP,         1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd35,           1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'hffff_ffff,    1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'hffff_ffff,    1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'd2,            1'b1, 64'd1, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, TOK_END,          1'b0, 64'd0, CAUSE_REG},
        '{REQ_RESTART, 12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, 32'hffff_ffff,    1'b1, 64'd0, CAUSE_UNKNOWN},
        '{REQ_RESTART, 12'd0,   8'h00, 32'd0,            1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, TOK_END,          1'b1, 64'd0, CAUSE_END},
        '{REQ_RESTART, 12'hfff, 8'hff, 32'hffff_ffff,    1'b0, 64'd0, CAUSE_REG},
        '{REQ_STRUCT,  12'd0,   8'h00, TOK_END,          1'b1, 64'd0, CAUSE_END}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic [REQ_W-1:0]        s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [CAUSE_W-1:0]      m_axis_tuser;

    fdt_memory_size_scanner #(
        .STRINGS_DEPTH (STR_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------
    // Scan state mirror: our own copy of the strings store and walk state
    // ------------------------------------------------------------------
    logic [7:0]   str_mem     [STR_DEPTH];
    bit           str_written [STR_DEPTH];
    scan_phase_t  scan_ph;
    bit           in_mem;
    bit           name_second;
    logic [31:0]  plen;
    logic [30:0]  skip_left;
    logic [27:0]  ent_left;
    logic [1:0]   ent_word;
    logic [31:0]  size_hi;
    logic [63:0]  run_total;
    bit           scan_done;

    region_total_t awaited_totals [$];

    // Offsets known to hold a written byte pair; the first set was loaded with 'r' and 'g'
    logic [11:0]  reg_offsets   [$];
    logic [11:0]  plain_offsets [$];

    int           mismatch_count;
    int           cycle_count;
    int           items_sent;
    int           totals_expected;
    int           totals_checked;
    int           load_count;
    int           restart_count;

    // Shared between the sender, the receiver and the scoreboard
    bit           steady;
    bit           hold_req;
    bit           row_has_total;
    logic [63:0]  row_total;
    logic [1:0]   row_cause;

    function automatic bit any_zero_byte(input logic [31:0] w);
        return w[31:24] == 8'h00 || w[23:16] == 8'h00 || w[15:8] == 8'h00 || w[7:0] == 8'h00;
    endfunction

    function automatic void clear_scan();
        scan_ph     = SC_TOKEN;
        in_mem      = 1'b0;
        name_second = 1'b0;
        plen        = '0;
        skip_left   = '0;
        ent_left    = '0;
        ent_word    = '0;
        size_hi     = '0;
        run_total   = '0;
        scan_done   = 1'b0;
    endfunction

    // Advance the walk by one structure word; return 1 when it closes with a total
    function automatic bit scan_struct_word(input logic [31:0] w, output region_total_t res);
        bit fire;
        bit ends;
        bit name_ok;
        fire = 1'b0;
        res  = '{total: 64'd0, cause: CAUSE_REG};
        case (scan_ph)
            SC_TOKEN: begin
                run_total = '0;
                if (w == TOK_BEGIN_NODE) begin
                    in_mem      = 1'b0;
                    name_second = 1'b0;
                    scan_ph     = SC_NAME;
                end else if (w == TOK_PROP) begin
                    scan_ph = SC_PROP_LEN;
                end else if (w == TOK_END_NODE) begin
                    in_mem = 1'b0;
                end else if (w == TOK_NOP) begin
                end else if (w == TOK_END) begin
                    fire      = 1'b1;
                    res.cause = CAUSE_END;
                end else begin
                    fire      = 1'b1;
                    res.cause = CAUSE_UNKNOWN;
                end
            end
            SC_NAME: begin
                if (!name_second) begin
                    // a name over before its second word can never be a memory node
                    ends        = any_zero_byte(w);
                    in_mem      = !ends && w[31:24] == CH_M && w[23:16] == CH_E;
                    name_second = 1'b1;
                    scan_ph     = ends ? SC_TOKEN : SC_NAME;
                end else begin
                    if (!(w[31:24] != 8'h00 && w[23:16] == CH_Y))
                        in_mem = 1'b0;
                    scan_ph = any_zero_byte(w) ? SC_TOKEN : SC_NAME_TAIL;
                end
            end
            SC_NAME_TAIL: begin
                if (any_zero_byte(w))
                    scan_ph = SC_TOKEN;
            end
            SC_PROP_LEN: begin
                plen    = w;
                scan_ph = SC_PROP_OFF;
            end
            SC_PROP_OFF: begin
                name_ok = 1'b0;
                if (w <= 32'(STR_LAST_OFF))
                    name_ok = str_mem[w[11:0]] == CH_R && str_mem[w[11:0] + 12'd2] == CH_G;
                if (in_mem && name_ok) begin
                    ent_left = plen[31:4];
                    if (ent_left == '0) begin
                        fire = 1'b1;
                    end else begin
                        ent_word  = '0;
                        run_total = '0;
                        scan_ph   = SC_SUM;
                    end
                end else begin
                    skip_left = {1'b0, plen[31:2]} + 31'(plen[1:0] != 2'b00);
                    scan_ph   = (skip_left != '0) ? SC_SKIP : SC_TOKEN;
                end
            end
            SC_SKIP: begin
                if (skip_left != '0)
                    skip_left = skip_left - 31'd1;
                if (skip_left == '0)
                    scan_ph = SC_TOKEN;
            end
            SC_SUM: begin
                if (ent_word == 2'd2) begin
                    size_hi = w;
                end else if (ent_word == 2'd3) begin
                    run_total = run_total + {size_hi, w};
                    if (ent_left != '0)
                        ent_left = ent_left - 28'd1;
                    if (ent_left == '0) begin
                        ent_word  = '0;
                        fire      = 1'b1;
                        res.total = run_total;
                    end
                end
                if (!fire)
                    ent_word = ent_word + 2'd1;
            end
            default: scan_ph = SC_TOKEN;
        endcase
        if (fire) begin
            scan_done = 1'b1;
            scan_ph   = SC_TOKEN;
        end
        return fire;
    endfunction

    function automatic bit predict_transfer(input logic [REQ_W-1:0] req, input logic [11:0] addr,
                                            input logic [7:0] data_byte, input logic [31:0] w,
                                            output region_total_t res);
        bit fire;
        fire = 1'b0;
        res  = '{total: 64'd0, cause: CAUSE_REG};
        case (req)
            REQ_LOAD: begin
                str_mem[addr]     = data_byte;
                str_written[addr] = 1'b1;
                load_count++;
            end
            REQ_RESTART: begin
                clear_scan();
                restart_count++;
            end
            REQ_STRUCT: begin
                if (!scan_done)
                    fire = scan_struct_word(w, res);
            end
            default: ;
        endcase
        return fire;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle guard
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: sample both streams at the rising edge. A result passes stage 1
    // and the output register after its cause, so checking before predicting in the same edge
    // never pairs a result with its own input transfer.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        region_total_t want;
        region_total_t got;
        bit            fire;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                totals_checked++;
                if (awaited_totals.size() == 0)
                begin
                    flag_mismatch($sformatf("total %h cause %0d with nothing awaited",
                                            m_axis_tdata, m_axis_tuser));
                end
                else
                begin
                    want = awaited_totals.pop_front();
                    if (m_axis_tdata !== want.total)
                        flag_mismatch($sformatf("total_size %h, want %h", m_axis_tdata, want.total));
                    if (m_axis_tuser !== want.cause)
                        flag_mismatch($sformatf("finish_cause %0d, want %0d", m_axis_tuser,
                                                want.cause));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                fire = predict_transfer(s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[19:12],
                                        s_axis_tdata[51:20], got);
                // rows of the opening walk carry their total typed in
                if (row_has_total)
                begin
                    awaited_totals.push_back('{total: row_total, cause: row_cause});
                    totals_expected++;
                end
                else if (fire)
                begin
                    awaited_totals.push_back(got);
                    totals_expected++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drop tready at random, never during the steady stretch, and
    // hold it low for a long count once on request so the block backs up.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = steady || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one transfer and hold it until accepted. An offset word that would
    // read a never-written string byte is pushed out of the store's range.
    task automatic offer(input logic [REQ_W-1:0] req, input logic [11:0] addr,
                         input logic [7:0] data_byte, input logic [31:0] word,
                         input bit has_total, input logic [63:0] total,
                         input logic [CAUSE_W-1:0] cause);
        logic [31:0] w;
        int          gap;
        w = word;
        @(negedge clk);
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            gap = $urandom_range(1, 2);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (req == REQ_STRUCT && !scan_done && scan_ph == SC_PROP_OFF && w <= 32'(STR_LAST_OFF))
        begin
            if (!(str_written[w[11:0]] && str_written[w[11:0] + 12'd2]))
                w = w | 32'h0000_1000;
        end
        if (req != REQ_UNUSED && !(req == REQ_STRUCT && scan_done))
            items_sent++;
        row_has_total = has_total;
        row_total     = total;
        row_cause     = cause;
        s_axis_tdata  = {4'h0, w, data_byte, addr};
        s_axis_tuser  = req;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic offer_word(input logic [31:0] w);
        offer(REQ_STRUCT, 12'($urandom), 8'($urandom), w, 1'b0, 64'd0, CAUSE_REG);
    endtask

    task automatic offer_other(input logic [REQ_W-1:0] req);
        offer(req, 12'($urandom), 8'($urandom), $urandom, 1'b0, 64'd0, CAUSE_REG);
    endtask

    function automatic logic [7:0] nz();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [31:0] nz_word();
        return {nz(), nz(), nz(), nz()};
    endfunction

    // A name word that ends the name at a random byte
    function automatic logic [31:0] stop_word();
        logic [31:0] w;
        w = nz_word();
        w[8 * $urandom_range(0, 3) +: 8] = 8'h00;
        return w;
    endfunction

    function automatic logic [31:0] pick_offset(input bit as_reg);
        if (as_reg && reg_offsets.size() > 0 && $urandom_range(0, 9) != 0)
            return 32'(reg_offsets[$urandom_range(0, reg_offsets.size() - 1)]);
        case ($urandom_range(0, 3))
            0: if (plain_offsets.size() > 0)
                   return 32'(plain_offsets[$urandom_range(0, plain_offsets.size() - 1)]);
            1: if (reg_offsets.size() > 0)
                   return 32'(reg_offsets[$urandom_range(0, reg_offsets.size() - 1)]);
            2: return 32'(STR_DEPTH - 2 + $urandom_range(0, 1));
            default: ;
        endcase
        return $urandom | 32'h0000_1000;
    endfunction

    // Load a byte pair two apart; a reg pair spells 'r' and 'g'
    task automatic load_pair(input bit as_reg);
        logic [11:0] a;
        a = 12'($urandom_range(0, STR_LAST_OFF));
        offer(REQ_LOAD, a, as_reg ? CH_R : 8'($urandom), $urandom, 1'b0, 64'd0, CAUSE_REG);
        if ($urandom_range(0, 1) == 1)
            offer(REQ_LOAD, a + 12'd1, 8'($urandom), $urandom, 1'b0, 64'd0, CAUSE_REG);
        offer(REQ_LOAD, a + 12'd2, as_reg ? CH_G : 8'($urandom), $urandom, 1'b0, 64'd0,
              CAUSE_REG);
        if (as_reg)
            reg_offsets.push_back(a);
        else
            plain_offsets.push_back(a);
    endtask

    task automatic send_name(input bit mem);
        logic [31:0] w0;
        logic [31:0] w1;
        w0 = mem ? {CH_M, CH_E, nz(), nz()} : nz_word();
        if ($urandom_range(0, 7) == 0)
            w0 = mem ? {CH_M, CH_E, 8'h00, nz()} : stop_word();
        offer_word(w0);
        if (any_zero_byte(w0))
            return;
        w1 = {nz(), mem ? CH_Y : nz(), nz(), nz()};
        case ($urandom_range(0, 3))
            0: w1[7:0]   = 8'h00;
            1: w1[15:8]  = 8'h00;
            2: ;
            default: if ($urandom_range(0, 3) == 0) w1[31:24] = 8'h00; else w1[7:0] = 8'h00;
        endcase
        offer_word(w1);
        if (!any_zero_byte(w1))
        begin
            repeat ($urandom_range(0, 2)) offer_word(nz_word());
            offer_word(stop_word());
        end
    endtask

    task automatic send_prop(input bit as_reg, input bit mem);
        logic [31:0] len;
        int          n;
        offer_word(TOK_PROP);
        if (as_reg)
        begin
            n   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
            len = 32'(16 * n) + (($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 15)) : 32'd0);
        end
        else
        begin
            n   = 0;
            len = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 40));
        end
        offer_word(len);
        offer_word(pick_offset(as_reg));
        if (as_reg && mem)
        begin
            repeat (n)
            begin
                offer_word($urandom);
                offer_word($urandom);
                offer_word(($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom);
                offer_word(($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom);
            end
        end
        else
        begin
            repeat ((len + 3) / 4) offer_word($urandom);
        end
    endtask

    // One restart and a small tree; most trees close in a memory node's reg
    // property, the rest with END, an unknown token or loose noise.
    task automatic run_tree();
        int nodes;
        int ending;
        bit mem;
        bit last;
        offer_other(REQ_RESTART);
        if ($urandom_range(0, 9) < 3)
            load_pair(1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) < 2)
            offer_other(REQ_LOAD);
        if ($urandom_range(0, 19) == 0)
            offer_other(REQ_UNUSED);
        ending = $urandom_range(0, 9);
        nodes  = $urandom_range(1, 3);
        for (int k = 0; k < nodes; k++)
        begin
            last = (k == nodes - 1);
            mem  = (last && ending < 6) || $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 4) == 0)
                offer_word(TOK_NOP);
            offer_word(TOK_BEGIN_NODE);
            send_name(mem);
            repeat ($urandom_range(0, 2)) send_prop(1'b0, mem);
            if (last && ending < 6)
                send_prop(1'b1, mem);
            else
                offer_word(TOK_END_NODE);
        end
        case (ending)
            6, 7: offer_word(TOK_END);
            8:    offer_word(($urandom_range(0, 1) == 1) ? 32'($urandom_range(5, 8))
                                                         : ($urandom | 32'h0000_0100));
            9:    repeat ($urandom_range(1, 4)) offer_word($urandom);
            default: ;
        endcase
        // words after a result are ignored until the next restart
        repeat ($urandom_range(0, 2)) offer_word($urandom);
    endtask

    // Hold the receiver off and keep offering result-making pairs
    task automatic squeeze_output();
        hold_req = 1'b1;
        repeat (16)
        begin
            offer_other(REQ_RESTART);
            offer_word(($urandom_range(0, 1) == 1) ? TOK_END : 32'hffff_fff0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        bit squeezed;
        opening_row_t row;
        squeezed        = 1'b0;
        mismatch_count  = 0;
        cycle_count     = 0;
        items_sent      = 0;
        totals_expected = 0;
        totals_checked  = 0;
        load_count      = 0;
        restart_count   = 0;
        steady          = 1'b0;
        hold_req        = 1'b0;
        row_has_total   = 1'b0;
        row_total       = '0;
        row_cause       = CAUSE_REG;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = REQ_LOAD;
        rst_n           = 1'b0;
        clear_scan();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < OPENING_ROWS; i++)
        begin
            row = OPENING[i];
            offer(row.req, row.addr, row.data_byte, row.word, row.has_total, row.total, row.cause);
        end
        reg_offsets.push_back(12'd0);

        // Random trees until enough transfers have gone through
        while (items_sent < ITEM_GOAL)
        begin
            steady = (items_sent >= 220 && items_sent < 300);
            if (!squeezed && items_sent >= 120)
            begin
                squeezed = 1'b1;
                squeeze_output();
            end
            run_tree();
        end
        steady = 1'b0;

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        row_has_total = 1'b0;

        while (awaited_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_totals.size() != 0)
            flag_mismatch($sformatf("%0d totals never arrived", awaited_totals.size()));

        $display("Walked %0d transfers in (%0d string loads, %0d restarts), checked %0d totals,",
                 items_sent, load_count, restart_count, totals_checked);
        $display("with random gaps on both streams and one %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fdtms_pkg.sv
rtl/fdt_memory_size_scanner.sv
rtl/fdtms_checker.sv
bench/tb_top.sv
